// ===== rtl/iee_pkg.sv =====
// Package for the infix expression evaluator: types, codes and defaults.
package iee_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 16;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_SYNTAX  = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MOP_NONE = 2'd0,
        MOP_MUL  = 2'd1,
        MOP_DIV  = 2'd2
    } mop_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_DIV  = 2'd2,
        S_FOLD = 2'd3
    } state_t;

endpackage

// ===== rtl/infix_expression_evaluator_top.sv =====
// Each request is taken in S_IDLE; a digit after '*' then runs the shift-add multiply in S_MUL,
// a digit after '/' runs the restoring divide in S_DIV, and a '+' or '-' and the last request run a fold in S_FOLD.
// No new request is taken while a multiply, divide or fold is running; all of them use the shared
// add/subtract unit that does the shift-add multiply, restoring divide and the fold.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn, synchronous, active low) clears the evaluation state and m_valid; m_value and m_status are not reset.
module infix_expression_evaluator_top #(
    parameter int unsigned VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_symbol,
    input  logic                   s_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_value,
    output logic [1:0]             m_status
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
    localparam int unsigned W = VALUE_WIDTH;

    iee_pkg::state_t  state_reg, state_next;
    iee_pkg::mop_t    mop_reg, mop_next;
    iee_pkg::status_t err_reg, err_next;
    iee_pkg::status_t m_status_reg, m_status_next;

    logic [W-1:0]     sum_reg, sum_next;
    logic [W-1:0]     term_reg, term_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     m_value_reg, m_value_next;
    logic [3:0]       digit_reg, digit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sub_reg, sub_next;
    logic             newsub_reg, newsub_next;
    logic             expect_reg, expect_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;

    // Shared add/subtract unit; the top bit of the result is the borrow.
    logic [W:0]   alu_a, alu_b;
    logic         alu_sub;
    logic [W+1:0] alu_res;

    logic             accept;
    logic             is_digit, is_op;
    logic [3:0]       sym_digit;
    iee_pkg::status_t fin_status;

    assign accept    = s_valid && s_ready;
    assign sym_digit = s_symbol[3:0];
    assign is_digit  = (s_symbol >= iee_pkg::CH_ZERO) && (s_symbol <= iee_pkg::CH_NINE);
    assign is_op     = (s_symbol == iee_pkg::CH_PLUS) || (s_symbol == iee_pkg::CH_MINUS) ||
                       (s_symbol == iee_pkg::CH_STAR) || (s_symbol == iee_pkg::CH_SLASH);

    always_comb begin
        alu_a   = {1'b0, sum_reg};
        alu_b   = {1'b0, term_reg};
        alu_sub = sub_reg;
        unique case (state_reg)
            iee_pkg::S_MUL: begin
                alu_a   = {acc_reg, 1'b0};
                alu_b   = digit_reg[cnt_reg[1:0]] ? {1'b0, term_reg} : '0;
                alu_sub = 1'b0;
            end
            iee_pkg::S_DIV: begin
                alu_a   = {rem_reg, acc_reg[W-1]};
                alu_b   = {{(W-3){1'b0}}, digit_reg};
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
        alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
    end

    always_comb begin
        if (err_reg != iee_pkg::ST_OK) begin
            fin_status = err_reg;
        end else if (expect_reg) begin
            fin_status = iee_pkg::ST_SYNTAX;
        end else begin
            fin_status = iee_pkg::ST_OK;
        end
    end

    always_comb begin
        state_next    = state_reg;
        mop_next      = mop_reg;
        err_next      = err_reg;
        sum_next      = sum_reg;
        term_next     = term_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        digit_next    = digit_reg;
        cnt_next      = cnt_reg;
        sub_next      = sub_reg;
        newsub_next   = newsub_reg;
        expect_next   = expect_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        s_ready       = (state_reg == iee_pkg::S_IDLE);

        unique case (state_reg)
            iee_pkg::S_IDLE: begin
                if (accept) begin
                    last_next = s_last;
                    if (s_last) begin
                        state_next = iee_pkg::S_FOLD;
                    end
                    if (err_reg == iee_pkg::ST_OK) begin
                        if (is_digit) begin
                            if (!expect_reg) begin
                                err_next = iee_pkg::ST_SYNTAX;
                            end else if (mop_reg == iee_pkg::MOP_MUL) begin
                                expect_next = 1'b0;
                                digit_next  = sym_digit;
                                acc_next    = '0;
                                cnt_next    = CNT_W'(3);
                                state_next  = iee_pkg::S_MUL;
                            end else if (mop_reg == iee_pkg::MOP_DIV) begin
                                if (sym_digit == 4'd0) begin
                                    err_next = iee_pkg::ST_DIVZERO;
                                end else begin
                                    expect_next = 1'b0;
                                    digit_next  = sym_digit;
                                    acc_next    = term_reg;
                                    rem_next    = '0;
                                    cnt_next    = CNT_W'(W - 1);
                                    state_next  = iee_pkg::S_DIV;
                                end
                            end else begin
                                expect_next = 1'b0;
                                term_next   = {{(W-4){1'b0}}, sym_digit};
                            end
                        end else if (is_op) begin
                            if (expect_reg) begin
                                err_next = iee_pkg::ST_SYNTAX;
                            end else begin
                                expect_next = 1'b1;
                                if (s_symbol == iee_pkg::CH_STAR) begin
                                    mop_next = iee_pkg::MOP_MUL;
                                end else if (s_symbol == iee_pkg::CH_SLASH) begin
                                    mop_next = iee_pkg::MOP_DIV;
                                end else begin
                                    // A trailing '+' or '-' ends in a syntax error, so
                                    // only a non-final one needs the fold.
                                    newsub_next = (s_symbol == iee_pkg::CH_MINUS);
                                    state_next  = iee_pkg::S_FOLD;
                                end
                            end
                        end else begin
                            err_next = iee_pkg::ST_UNKNOWN;
                        end
                    end
                end
            end
            iee_pkg::S_MUL: begin
                // Most significant digit bit first: acc = 2*acc + bit*term.
                acc_next = alu_res[W-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    term_next  = alu_res[W-1:0];
                    state_next = last_reg ? iee_pkg::S_FOLD : iee_pkg::S_IDLE;
                end
            end
            iee_pkg::S_DIV: begin
                // Restoring step; quotient bits shift into acc as dividend bits leave it.
                if (!alu_res[W+1]) begin
                    rem_next = alu_res[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = alu_a[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    term_next  = acc_next;
                    state_next = last_reg ? iee_pkg::S_FOLD : iee_pkg::S_IDLE;
                end
            end
            iee_pkg::S_FOLD: begin
                if (!last_reg) begin
                    sum_next   = alu_res[W-1:0];
                    sub_next   = newsub_reg;
                    term_next  = '0;
                    mop_next   = iee_pkg::MOP_NONE;
                    state_next = iee_pkg::S_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = fin_status;
                    m_value_next  = (fin_status == iee_pkg::ST_OK) ? alu_res[W-1:0] : '0;
                    sum_next      = '0;
                    sub_next      = 1'b0;
                    term_next     = '0;
                    mop_next      = iee_pkg::MOP_NONE;
                    expect_next   = 1'b1;
                    err_next      = iee_pkg::ST_OK;
                    last_next     = 1'b0;
                    state_next    = iee_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = iee_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iee_pkg::S_IDLE;
            mop_reg     <= iee_pkg::MOP_NONE;
            err_reg     <= iee_pkg::ST_OK;
            sum_reg     <= '0;
            term_reg    <= '0;
            sub_reg     <= 1'b0;
            newsub_reg  <= 1'b0;
            expect_reg  <= 1'b1;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mop_reg     <= mop_next;
            err_reg     <= err_next;
            sum_reg     <= sum_next;
            term_reg    <= term_next;
            sub_reg     <= sub_next;
            newsub_reg  <= newsub_next;
            expect_reg  <= expect_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        digit_reg    <= digit_next;
        cnt_reg      <= cnt_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    // A result that carries an error reports a value of zero.
    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != iee_pkg::ST_OK) |-> m_value_reg == '0)
        else $error("error result with nonzero value");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == iee_pkg::S_DIV |-> digit_reg != 4'd0)
        else $error("divide started with zero divisor");

    // Multiply and divide only run while no error is recorded.
    a_iter_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == iee_pkg::S_MUL) || (state_reg == iee_pkg::S_DIV) |->
        err_reg == iee_pkg::ST_OK)
        else $error("arithmetic step after an error");

    // A plain digit with no pending multiply or divide loads the term at once.
    a_digit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_digit && expect_reg && (err_reg == iee_pkg::ST_OK) &&
        (mop_reg == iee_pkg::MOP_NONE) |=> term_reg == W'($past(sym_digit)))
        else $error("digit not loaded into term");
`endif

endmodule

// ===== dv/tb_infix_expression_evaluator_top.sv =====
// Self-checking testbench for the infix expression evaluator top level.
module tb_infix_expression_evaluator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VW = iee_pkg::VALUE_WIDTH_DEF;
    localparam int TOTAL_REQUESTS = 1775;
    localparam int CALM_TAIL = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 20;

    typedef struct {
        logic [7:0] symbol;
        logic       last;
    } request_t;

    typedef struct {
        logic [VW-1:0]    value;
        iee_pkg::status_t status;
    } expr_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [7:0]    s_symbol = 8'h00;
    logic          s_last = 1'b0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [VW-1:0] m_value;
    logic [1:0]    m_status;

    request_t     symbols_to_send[$];
    expr_result_t results_due[$];
    int           mismatches = 0;
    int           results_checked = 0;

    // Evaluation state of the expected-value calculator.
    logic [VW-1:0]    sum_acc = '0;
    logic [VW-1:0]    term_acc = '0;
    bit               sub_pending = 1'b0;
    bit               want_digit = 1'b1;
    iee_pkg::mop_t    mul_op = iee_pkg::MOP_NONE;
    iee_pkg::status_t err_code = iee_pkg::ST_OK;

    infix_expression_evaluator_top #(.VALUE_WIDTH(VW)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_symbol (s_symbol),
        .s_last   (s_last),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [VW-1:0] folded_sum();
        return sub_pending ? sum_acc - term_acc : sum_acc + term_acc;
    endfunction

    // Advances the expected evaluation by one accepted request.
    task automatic evaluate_symbol(input logic [7:0] ch, input logic last);
        logic [VW-1:0] digit;
        expr_result_t  res;
        digit = VW'(ch - iee_pkg::CH_ZERO);
        if (err_code == iee_pkg::ST_OK) begin
            if (ch >= iee_pkg::CH_ZERO && ch <= iee_pkg::CH_NINE) begin
                if (!want_digit) begin
                    err_code = iee_pkg::ST_SYNTAX;
                end else if (mul_op == iee_pkg::MOP_DIV && digit == '0) begin
                    err_code = iee_pkg::ST_DIVZERO;
                end else begin
                    case (mul_op)
                        iee_pkg::MOP_MUL: term_acc = term_acc * digit;
                        iee_pkg::MOP_DIV: term_acc = term_acc / digit;
                        default: term_acc = digit;
                    endcase
                    want_digit = 1'b0;
                end
            end else if (ch == iee_pkg::CH_PLUS || ch == iee_pkg::CH_MINUS ||
                         ch == iee_pkg::CH_STAR || ch == iee_pkg::CH_SLASH) begin
                if (want_digit) begin
                    err_code = iee_pkg::ST_SYNTAX;
                end else begin
                    if (ch == iee_pkg::CH_PLUS || ch == iee_pkg::CH_MINUS) begin
                        sum_acc = folded_sum();
                        sub_pending = (ch == iee_pkg::CH_MINUS);
                        term_acc = '0;
                        mul_op = iee_pkg::MOP_NONE;
                    end else begin
                        mul_op = (ch == iee_pkg::CH_STAR) ? iee_pkg::MOP_MUL : iee_pkg::MOP_DIV;
                    end
                    want_digit = 1'b1;
                end
            end else begin
                err_code = iee_pkg::ST_UNKNOWN;
            end
        end
        if (last) begin
            // A dangling operator only counts if nothing failed earlier.
            if (want_digit && err_code == iee_pkg::ST_OK)
                err_code = iee_pkg::ST_SYNTAX;
            res.value = (err_code == iee_pkg::ST_OK) ? folded_sum() : '0;
            res.status = err_code;
            results_due.push_back(res);
            sum_acc = '0;
            term_acc = '0;
            sub_pending = 1'b0;
            want_digit = 1'b1;
            mul_op = iee_pkg::MOP_NONE;
            err_code = iee_pkg::ST_OK;
        end
    endtask

    task automatic queue_symbol(input logic [7:0] ch, input logic last);
        request_t req;
        req.symbol = ch;
        req.last = last;
        symbols_to_send.push_back(req);
    endtask

    task automatic queue_text(input string txt, input bit ends = 1'b1);
        for (int i = 0; i < txt.len(); i++)
            queue_symbol(txt[i], ends && (i == txt.len() - 1));
    endtask

    function automatic logic [7:0] pick_operator(input bit mul_heavy);
        int pick;
        pick = mul_heavy ? $urandom_range(0, 9) : $urandom_range(0, 3);
        case (pick)
            0: return iee_pkg::CH_PLUS;
            1: return iee_pkg::CH_MINUS;
            2: return iee_pkg::CH_SLASH;
            default: return iee_pkg::CH_STAR;
        endcase
    endfunction

    // Mostly well-formed expressions with random content; the rest get one random change that may break them.
    task automatic queue_random_expression();
        logic [7:0] sym[$];
        int         n_dig;
        int         pos;
        bit         mul_heavy;
        mul_heavy = ($urandom_range(0, 4) == 0);
        n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        for (int k = 0; k < n_dig; k++) begin
            if (k > 0)
                sym.push_back(pick_operator(mul_heavy));
            sym.push_back(8'(iee_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, sym.size() - 1);
            case ($urandom_range(0, 5))
                0: sym[pos] = 8'($urandom_range(0, 255));
                1: sym[pos] = 8'(iee_pkg::CH_ZERO + $urandom_range(0, 9));
                2: sym.push_back(pick_operator(1'b0));
                3: sym.push_front(pick_operator(1'b0));
                4: sym[pos] = pick_operator(1'b0);
                default: begin
                    sym.delete();
                    repeat ($urandom_range(1, 4))
                        sym.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        foreach (sym[i])
            queue_symbol(sym[i], i == sym.size() - 1);
    endtask

    // Sender: takes requests from the queue, with random idle bursts except near the end.
    always @(posedge aclk) begin : driver
        request_t req;
        int       idle_left;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_symbol <= 8'h00;
            s_last <= 1'b0;
            idle_left = 0;
        end else begin
            if (s_valid && s_ready)
                evaluate_symbol(s_symbol, s_last);
            if (!s_valid || s_ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (symbols_to_send.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    idle_left = $urandom_range(1, 6) - 1;
                    s_valid <= 1'b0;
                end else if (symbols_to_send.size() > 0) begin
                    req = symbols_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_symbol <= req.symbol;
                    s_last <= req.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest expected one and stalls at random.
    // Once, it holds off long enough for the block to back up into its input.
    always @(posedge aclk) begin : monitor
        expr_result_t want;
        int           stall_left;
        int           hold_left;
        bit           held_once;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            held_once = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: value %0d status %0d", m_value, m_status);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (m_value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_value);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatches++;
                    end
                end
                results_checked++;
            end
            if (!held_once && results_checked >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (symbols_to_send.size() <= CALM_TAIL) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        // Directed expressions: extremes, every operator and each error path.
        queue_text("7");
        queue_text("0-9");
        queue_text("8/3*9-4");
        queue_text("9/0");
        queue_text("+");
        queue_text("12");
        queue_text("3*");
        queue_symbol(8'hFF, 1'b0);
        queue_text("5");
        // The division by zero must win over the later unknown symbol.
        queue_text("5/0", 1'b0);
        queue_symbol(8'h00, 1'b1);

        while (symbols_to_send.size() < TOTAL_REQUESTS)
            queue_random_expression();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (symbols_to_send.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
        repeat (VW + 8) @(posedge aclk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
